// ----- src/periodic_timer_table_unit_defines.svh -----
// Assertion helpers shared by the timer table modules
`ifndef PERIODIC_TIMER_TABLE_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define PTT_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("timer table assertion failed");

// next-cycle implication
`define PTT_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("timer table assertion failed");

`endif

// ----- src/ptt_pkg.sv -----
// ---------------------------------------------------------------------------
// ptt_pkg
// Types, codes and constants of the periodic timer table.
// ---------------------------------------------------------------------------
package ptt_pkg;

    localparam int TIMER_SLOTS_DEF = 16;

    localparam int PERIOD_W = 24;
    localparam int REP_W    = 16;
    localparam int ID_W     = 32;
    localparam int REM_W    = 25;
    localparam int STEP_W   = 16;
    localparam int KIND_W   = 3;

    localparam logic [STEP_W-1:0] TICK_STEP_RESET = 16'd100;
    localparam logic [REP_W-1:0]  FOREVER_MARK    = 16'hFFFF;

    // input function codes
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_CANCEL = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] EV_ADDED     = 3'd0;
    localparam logic [KIND_W-1:0] EV_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] EV_CANCELLED = 3'd2;
    localparam logic [KIND_W-1:0] EV_CLEARED   = 3'd3;
    localparam logic [KIND_W-1:0] EV_FIRED     = 3'd4;
    localparam logic [KIND_W-1:0] EV_DONE      = 3'd5;

    typedef struct packed {
        logic latch;      // capture the input transaction
        logic tick_init;  // clear visit marks, restart scan
        logic exec;       // perform add/cancel/clear and emit its result
        logic scan_step;  // examine one slot for the next lowest id
        logic visit;      // count down the chosen timer
        logic finish;     // drop spent timers, emit tick done
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic found;
        logic fire;
        logic out_free;
    } t_sts;

endpackage

// ----- src/ptt_ctrl.sv -----
// ---------------------------------------------------------------------------
// ptt_ctrl
// Sequencer of the timer table: accepts items and steps the datapath.
// ---------------------------------------------------------------------------
`include "periodic_timer_table_unit_defines.svh"

module ptt_ctrl
    import ptt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    output logic       o_in_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_VISIT,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    if (i_func == FUNC_TICK) begin
                        o_cmd.tick_init = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = i_sts.found ? S_VISIT : S_FINISH;
                end
            end
            S_VISIT: begin
                if (!i_sts.fire || i_sts.out_free) begin
                    o_cmd.visit = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `PTT_ASSERT_NOW(a_emit_room, i_clk, i_rst_n,
        o_cmd.exec || o_cmd.finish || (o_cmd.visit && i_sts.fire), i_sts.out_free)
    `PTT_ASSERT_NEXT(a_tick_scans, i_clk, i_rst_n, o_cmd.tick_init, r_state == S_SCAN)
    `PTT_ASSERT_NEXT(a_visit_rescans, i_clk, i_rst_n, o_cmd.visit, r_state == S_SCAN)

endmodule

// ----- src/ptt_dpath.sv -----
// ---------------------------------------------------------------------------
// ptt_dpath
// Timer slot storage, id-order scan, countdown and result register.
// ---------------------------------------------------------------------------
`include "periodic_timer_table_unit_defines.svh"

module ptt_dpath
    import ptt_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [1:0]          i_func,
    input  logic [PERIOD_W-1:0] i_period_ms,
    input  logic [REP_W-1:0]    i_repeat_count,
    input  logic [ID_W-1:0]     i_target_id,
    input  logic [STEP_W-1:0]   i_tick_step,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [KIND_W-1:0]   o_event_kind,
    output logic [ID_W-1:0]     o_timer_id,
    output logic                o_last
);

    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(TIMER_SLOTS - 1);

    logic [TIMER_SLOTS-1:0] r_valid;
    logic [TIMER_SLOTS-1:0] r_visited;
    logic [ID_W-1:0]        r_id     [TIMER_SLOTS];
    logic [PERIOD_W-1:0]    r_period [TIMER_SLOTS];
    logic [REM_W-1:0]       r_rem    [TIMER_SLOTS];
    logic [REP_W-1:0]       r_rep    [TIMER_SLOTS];
    logic [ID_W-1:0]        r_next_id;

    logic [1:0]             r_func;
    logic [PERIOD_W-1:0]    r_period_in;
    logic [REP_W-1:0]       r_rep_in;
    logic [ID_W-1:0]        r_target;

    logic [SW-1:0]          r_p;
    logic [SW-1:0]          r_best;
    logic                   r_best_valid;
    logic [ID_W-1:0]        r_best_id;

    logic                   r_out_valid;
    logic [KIND_W-1:0]      r_kind;
    logic [ID_W-1:0]        r_oid;
    logic                   r_last;

    logic                   full;
    logic [SW-1:0]          free_idx;
    logic                   cand_ok;
    logic [REM_W:0]         diff;
    logic                   fire;
    logic [REP_W-1:0]       rep_store;
    logic [ID_W-1:0]        id_new;
    logic                   out_free;

    always_comb begin
        free_idx = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) free_idx = SW'(i);
        end
    end

    assign full     = &r_valid;
    assign id_new   = r_next_id + 32'd1;
    assign out_free = !r_out_valid || i_out_ready;

    // strict compare: on equal ids the lower slot, seen first, stays chosen
    assign cand_ok = r_valid[r_p] && !r_visited[r_p] &&
                     (!r_best_valid || (r_id[r_p] < r_best_id));

    assign diff = {r_rem[r_best][REM_W-1], r_rem[r_best]} - (REM_W+1)'(i_tick_step);
    assign fire = diff[REM_W] || (diff == '0);

    always_comb begin
        if (r_rep_in[REP_W-1])      rep_store = FOREVER_MARK;
        else if (r_rep_in == '0)    rep_store = REP_W'(1);
        else                        rep_store = r_rep_in;
    end

    assign o_sts.scan_last = (r_p == LAST_SLOT);
    assign o_sts.found     = r_best_valid || cand_ok;
    assign o_sts.fire      = fire;
    assign o_sts.out_free  = out_free;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_next_id    <= '0;
            r_out_valid  <= 1'b0;
            r_best_valid <= 1'b0;
        end else begin
            // a new result only loads when the register is free
            if (i_cmd.exec || i_cmd.finish || (i_cmd.visit && fire)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.tick_init) r_best_valid <= 1'b0;
            if (i_cmd.scan_step && cand_ok) r_best_valid <= 1'b1;
            if (i_cmd.visit) r_best_valid <= 1'b0;
            if (i_cmd.exec) begin
                case (r_func)
                    FUNC_ADD: begin
                        if (!full) begin
                            r_valid[free_idx] <= 1'b1;
                            r_next_id         <= id_new;
                        end
                    end
                    FUNC_CANCEL: begin
                        for (int i = 0; i < TIMER_SLOTS; i++) begin
                            if (r_id[i] == r_target) r_valid[i] <= 1'b0;
                        end
                    end
                    FUNC_CLEAR: r_valid <= '0;
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                for (int i = 0; i < TIMER_SLOTS; i++) begin
                    if (r_rep[i] == '0) r_valid[i] <= 1'b0;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func      <= i_func;
            r_period_in <= i_period_ms;
            r_rep_in    <= i_repeat_count;
            r_target    <= i_target_id;
        end
        if (i_cmd.tick_init) begin
            r_visited <= '0;
            r_p       <= '0;
        end
        if (i_cmd.scan_step) begin
            if (cand_ok) begin
                r_best    <= r_p;
                r_best_id <= r_id[r_p];
            end
            if (r_p != LAST_SLOT) r_p <= r_p + SW'(1);
        end
        if (i_cmd.visit) begin
            r_visited[r_best] <= 1'b1;
            r_p               <= '0;
            if (fire) begin
                r_rem[r_best] <= REM_W'({1'b0, r_period[r_best]});
                if (r_rep[r_best] != FOREVER_MARK && r_rep[r_best] != '0) begin
                    r_rep[r_best] <= r_rep[r_best] - REP_W'(1);
                end
                r_kind <= EV_FIRED;
                r_oid  <= r_id[r_best];
                r_last <= 1'b0;
            end else begin
                r_rem[r_best] <= diff[REM_W-1:0];
            end
        end
        if (i_cmd.exec) begin
            r_last <= 1'b1;
            case (r_func)
                FUNC_ADD: begin
                    if (full) begin
                        r_kind <= EV_FULL;
                        r_oid  <= '0;
                    end else begin
                        r_kind             <= EV_ADDED;
                        r_oid              <= id_new;
                        r_id[free_idx]     <= id_new;
                        r_period[free_idx] <= r_period_in;
                        r_rem[free_idx]    <= REM_W'({1'b0, r_period_in});
                        r_rep[free_idx]    <= rep_store;
                    end
                end
                FUNC_CANCEL: begin
                    r_kind <= EV_CANCELLED;
                    r_oid  <= '0;
                end
                FUNC_CLEAR: begin
                    r_kind <= EV_CLEARED;
                    r_oid  <= '0;
                end
                default: begin
                    r_kind <= EV_DONE;
                    r_oid  <= '0;
                end
            endcase
        end
        if (i_cmd.finish) begin
            r_kind <= EV_DONE;
            r_oid  <= '0;
            r_last <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_kind;
    assign o_timer_id   = r_oid;
    assign o_last       = r_last;

    `PTT_ASSERT_NEXT(a_add_grows, i_clk, i_rst_n,
        i_cmd.exec && r_func == FUNC_ADD && !full,
        $countones(r_valid) == $past($countones(r_valid)) + 1)
    `PTT_ASSERT_NOW(a_visit_has_pick, i_clk, i_rst_n, i_cmd.visit, r_best_valid)
    `PTT_ASSERT_NEXT(a_full_keeps_id, i_clk, i_rst_n,
        i_cmd.exec && r_func == FUNC_ADD && full, r_next_id == $past(r_next_id))

endmodule

// ----- src/periodic_timer_table_unit.sv -----
// ---------------------------------------------------------------------------
// periodic_timer_table_unit
// Table of periodic software timers with repeat counts and rising ids.
// ---------------------------------------------------------------------------
// Input stream: s_axis_tuser carries the function (tick, add, cancel,
// clear), s_axis_tdata the period, repeat count and cancel target.
// Output stream: m_axis_tuser carries the event kind, m_axis_tdata the
// timer id, m_axis_tlast marks the final result of an input transaction.
// One item is handled at a time; s_axis_tready is high only when idle.
// Add, cancel and clear load their one result from the exec state once
// the output register is free; the sequencer then returns to idle.
// A tick with k live timers runs k+1 scans over all TIMER_SLOTS slots,
// one slot per cycle through the id-order search, with a visit after each
// of the first k scans and a finish step at the end.
// A result sits in a single output register; while the receiver stalls the
// sequencer waits before the next result but the item is already accepted.
// The APB port holds tick_step_ms (reset 100); the user must write it only
// while idle (not enforced). Reset empties the table, zeroes the id counter.
// ---------------------------------------------------------------------------
module periodic_timer_table_unit
    import ptt_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // period_ms[23:0], repeat_count[39:24], target_id[71:40]
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // timer_id[31:0]
    output logic [2:0]  m_axis_tuser,  // event_kind[2:0]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cmd              cmd;
    t_sts              sts;
    logic [STEP_W-1:0] r_tick_step;

    // single register at address 0; reads return it at any address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_step <= TICK_STEP_RESET;
        end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'd0) begin
            r_tick_step <= pwdata[STEP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {16'd0, r_tick_step};

    ptt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_func     (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ptt_dpath #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (s_axis_tuser),
        .i_period_ms    (s_axis_tdata[23:0]),
        .i_repeat_count (s_axis_tdata[39:24]),
        .i_target_id    (s_axis_tdata[71:40]),
        .i_tick_step    (r_tick_step),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_event_kind   (m_axis_tuser),
        .o_timer_id     (m_axis_tdata),
        .o_last         (m_axis_tlast)
    );

endmodule

// ----- verif/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for periodic_timer_table_unit. A behavioural timer
// table predicts every result of each accepted transaction. Results are
// checked in order, field by field. Both streams idle at random, and the
// APB tick step is changed between phases.
// ---------------------------------------------------------------------------
module tb;
    import ptt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS    = TIMER_SLOTS_DEF;
    localparam int WD_LIMIT = 6000;
    localparam int HOLD_LEN = 400;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic              last;
    } t_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // period_ms[23:0], repeat_count[39:24], target_id[71:40]
    logic [1:0]  s_axis_tuser = '0;   // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // timer_id[31:0]
    logic [2:0]  m_axis_tuser;        // event_kind[2:0]
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    periodic_timer_table_unit u_top (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // timer table mirror
    bit                slot_live [SLOTS];
    bit [ID_W-1:0]     slot_tid  [SLOTS];
    int                slot_per  [SLOTS];
    int                slot_left [SLOTS];
    bit [REP_W-1:0]    slot_reps [SLOTS];
    bit [ID_W-1:0]     id_counter;
    bit [STEP_W-1:0]   step_ms = TICK_STEP_RESET;

    t_event pending_events[$];
    int     errors;
    int     idle_cycles;
    bit     steady;       // no random idling on either side while set (a requested hold-off still runs)
    bit     hold_req;
    int     hold_left;
    int     rx_stall;

    function automatic void push_event(logic [KIND_W-1:0] k, logic [ID_W-1:0] id, logic l);
        t_event e;
        e.kind = k;
        e.id   = id;
        e.last = l;
        pending_events.push_back(e);
    endfunction

    function automatic void run_tick();
        bit seen [SLOTS];
        int pick;
        for (int n = 0; n < SLOTS; n++) begin
            pick = -1;
            for (int i = 0; i < SLOTS; i++)
                if (slot_live[i] && !seen[i] && (pick < 0 || slot_tid[i] < slot_tid[pick]))
                    pick = i;
            if (pick < 0) break;
            seen[pick] = 1'b1;
            slot_left[pick] -= int'(step_ms);
            if (slot_left[pick] <= 0) begin
                if (slot_reps[pick] != FOREVER_MARK && slot_reps[pick] > 0)
                    slot_reps[pick]--;
                push_event(EV_FIRED, slot_tid[pick], 1'b0);
                slot_left[pick] = slot_per[pick];
            end
        end
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && slot_reps[i] == 0) slot_live[i] = 1'b0;
        push_event(EV_DONE, '0, 1'b1);
    endfunction

    function automatic void predict_table(logic [1:0] fn, logic [PERIOD_W-1:0] per,
                                          logic [REP_W-1:0] rep, logic [ID_W-1:0] tgt);
        int free_slot;
        case (fn)
            FUNC_TICK: run_tick();
            FUNC_ADD: begin
                free_slot = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!slot_live[i]) free_slot = i;
                if (free_slot < 0) begin
                    push_event(EV_FULL, '0, 1'b1);
                end else begin
                    id_counter++;
                    slot_live[free_slot] = 1'b1;
                    slot_tid[free_slot]  = id_counter;
                    slot_per[free_slot]  = int'(per);
                    slot_left[free_slot] = int'(per);
                    if (rep[REP_W-1])  slot_reps[free_slot] = FOREVER_MARK;
                    else if (rep == 0) slot_reps[free_slot] = REP_W'(1);
                    else               slot_reps[free_slot] = rep;
                    push_event(EV_ADDED, id_counter, 1'b1);
                end
            end
            FUNC_CANCEL: begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i] && slot_tid[i] == tgt) slot_live[i] = 1'b0;
                push_event(EV_CANCELLED, '0, 1'b1);
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
                push_event(EV_CLEARED, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called just after a rising edge; returns at the accepting edge, or after the random gap that follows it
    task automatic send_item(logic [1:0] fn, logic [PERIOD_W-1:0] per = 24'd1,
                             logic [REP_W-1:0] rep = '0, logic [ID_W-1:0] tgt = '0);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {tgt, rep, per};
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        predict_table(fn, per, rep, tgt);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_step(logic [STEP_W-1:0] val);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= '0;
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        step_ms = val;
    endtask

    function automatic logic [ID_W-1:0] live_id();
        int i;
        for (int t = 0; t < 8; t++) begin
            i = $urandom_range(0, SLOTS - 1);
            if (slot_live[i]) return slot_tid[i];
        end
        return $urandom();
    endfunction

    // receiver: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            if (!steady) begin
                case ($urandom_range(0, 99)) inside
                    [0:11]:  rx_stall = $urandom_range(1, 3);
                    [12:13]: rx_stall = $urandom_range(10, 30);
                    default: rx_stall = 0;
                endcase
            end
            m_axis_tready <= (rx_stall == 0);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_event want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result kind %0d id %0d", $time,
                         m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                want = pending_events.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $display("%0t: event_kind expected %0d actual %0d", $time,
                             want.kind, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata !== want.id) begin
                    $display("%0t: timer_id expected %0d actual %0d", $time,
                             want.id, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last expected %0d actual %0d", $time,
                             want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // watchdog on stalled progress
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
            $display("periodic_timer_table_unit regression: fail");
            $finish;
        end
    end

    task automatic test_basic();
        send_item(FUNC_TICK);
        send_item(FUNC_ADD, 24'd1, 16'd0);         // zero repeats behaves as one
        send_item(FUNC_TICK);
        send_item(FUNC_TICK);
        send_item(FUNC_ADD, 24'hFFFFFF, 16'hFFFF); // forever, longest period
        send_item(FUNC_ADD, 24'd150, 16'h7FFF);
        send_item(FUNC_ADD, 24'd0, 16'h8000);      // zero period fires every tick
        send_item(FUNC_ADD, 24'd200, 16'd2);
        repeat (4) send_item(FUNC_TICK);
        send_item(FUNC_CANCEL, , , 32'hFFFFFFFF);
        send_item(FUNC_CANCEL, , , 32'd3);
        send_item(FUNC_TICK);
        send_item(FUNC_CLEAR);
        send_item(FUNC_TICK);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < SLOTS + 1; i++)
            send_item(FUNC_ADD, 24'(100 * (i + 1)), 16'd1);
        send_item(FUNC_TICK);
        send_item(FUNC_CANCEL, , , 32'h0);
        send_item(FUNC_ADD, 24'd50, 16'hFFFF);
        send_item(FUNC_TICK);
        send_item(FUNC_CLEAR);
    endtask

    task automatic test_step_extremes();
        write_step(16'd0);
        send_item(FUNC_ADD, 24'd0, 16'd3);
        send_item(FUNC_ADD, 24'd5, 16'd1);
        repeat (4) send_item(FUNC_TICK);
        write_step(16'hFFFF);
        send_item(FUNC_ADD, 24'hFFFFFF, 16'd2);
        repeat (3) send_item(FUNC_TICK);
        send_item(FUNC_CLEAR);
    endtask

    task automatic test_backpressure();
        write_step(16'hFFFF);
        steady = 1'b1;
        for (int i = 0; i < SLOTS; i++) send_item(FUNC_ADD, 24'(i + 1), 16'hFFFF);
        hold_req = 1'b1;
        repeat (6) send_item(FUNC_TICK);
        send_item(FUNC_CLEAR);
        steady = 1'b0;
        drain();
    endtask

    task automatic random_item();
        logic [PERIOD_W-1:0] per;
        logic [REP_W-1:0]    rep;
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            case ($urandom_range(0, 9))
                0:       per = PERIOD_W'($urandom());
                1, 2, 3: per = PERIOD_W'($urandom_range(1, 3 * int'(step_ms) + 1));
                default: per = PERIOD_W'($urandom_range(1, 300));
            endcase
            case ($urandom_range(0, 19))
                0, 1, 2:    rep = REP_W'($urandom());
                3, 4, 5, 6: rep = 16'hFFFF;
                7, 8, 9:    rep = REP_W'($urandom_range(4, 20));
                default:    rep = REP_W'($urandom_range(0, 3));
            endcase
            send_item(FUNC_ADD, per, rep);
        end else if (r < 75) begin
            send_item(FUNC_TICK, PERIOD_W'($urandom()), REP_W'($urandom()), $urandom());
        end else if (r < 93) begin
            send_item(FUNC_CANCEL, PERIOD_W'($urandom()), REP_W'($urandom()),
                      ($urandom_range(0, 3) != 0) ? live_id() : 32'($urandom()));
        end else begin
            send_item(FUNC_CLEAR, PERIOD_W'($urandom()), REP_W'($urandom()), $urandom());
        end
    endtask

    task automatic test_random();
        logic [STEP_W-1:0] steps [5];
        steps = '{16'd100, 16'd1, 16'hFFFF, 16'd0, 16'd37};
        steps[4] = STEP_W'($urandom_range(1, 1000));
        foreach (steps[p]) begin
            write_step(steps[p]);
            steady = (p == 2);
            for (int n = 0; n < 74; n++) random_item();
            steady = 1'b0;
        end
    endtask

    initial begin
        errors = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic();
        test_full_table();
        test_step_extremes();
        test_backpressure();
        test_random();
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_events.size() == 0)
            $display("periodic_timer_table_unit regression: pass");
        else
            $display("periodic_timer_table_unit regression: fail");
        $finish;
    end

endmodule
